// File: design/mcpd_pkg.sv
// Shared constants for the marker/checksum packet deframer.
// Frame geometry, marker and type codes, result kinds. No dependencies.
package mcpd_pkg;

	localparam int PAYLOAD_BYTES = 8;

	localparam int HELLO_LEN = 9;
	localparam int DATA_LEN  = PAYLOAD_BYTES + 4;
	localparam int STORE_LEN = (HELLO_LEN > DATA_LEN) ? HELLO_LEN : DATA_LEN;
	localparam int FILL_W    = $clog2(STORE_LEN + 1);
	localparam int ADDR_W    = $clog2(STORE_LEN);

	localparam logic [7:0] MARK_BYTE  = 8'hA5;
	localparam logic [7:0] SUM_MASK   = 8'h5A;
	localparam logic [7:0] TYPE_HELLO = 8'h01;
	localparam logic [7:0] TYPE_DATA  = 8'h02;

	localparam logic [ADDR_W-1:0] ADDR_VERSION   = ADDR_W'(3);
	localparam logic [ADDR_W-1:0] ADDR_SIZE      = ADDR_W'(4);
	localparam logic [ADDR_W-1:0] ADDR_TOKEN_HI  = ADDR_W'(5);
	localparam logic [ADDR_W-1:0] ADDR_TOKEN_LO  = ADDR_W'(6);
	localparam logic [ADDR_W-1:0] ADDR_SESSION   = ADDR_W'(7);
	localparam logic [ADDR_W-1:0] ADDR_PAYLOAD   = ADDR_W'(3);
	localparam logic [ADDR_W-1:0] ADDR_PAY_LAST  = ADDR_W'(DATA_LEN - 2);

	localparam logic [1:0] EV_HELLO = 2'd0;
	localparam logic [1:0] EV_DATA  = 2'd1;
	localparam logic [1:0] EV_BAD   = 2'd2;

	typedef enum logic [3:0] {
		ST_RECV  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_LOAD  = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

endpackage

// File: design/mcpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the frame buffer of the deframer. No dependencies.
module mcpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/marker_checksum_packet_deframer.sv
// Top level of the marker/checksum packet deframer.
// Depends on mcpd_pkg and mcpd_ram (frame buffer).
//
// Usage:
//   rx channel (rx_valid/rx_ready/rx_byte) takes one received byte per transaction.
//   Result channel (out_valid/out_ready plus the event fields) gives one result per
//   transaction; run_last marks the final result caused by one input byte.
//   While a frame is being received, rx_ready is high and a byte is taken every
//   cycle. Marker hunting, type decode and the running checksum do not stall the stream.
//   When the checksum byte completes a frame, rx_ready drops until all of its
//   results have been taken:
//     bad checksum: result valid in the cycle after the checksum byte.
//     HELLO: the five body bytes are read back from the frame buffer, one RAM read
//       each through the fetch and load states; the result is valid after the last read.
//     DATA: each payload byte is one RAM read, so each result is valid after a fetch and
//       a load state that follow the previous one being taken (the first: the checksum byte).
//   The single read port of the frame buffer sets the readout rate.
//   A stalled receiver holds the result register; nothing is lost or repeated.
//   Reset clears the fill count and the sequencer and puts the block into hunting.
//   Frame buffer contents are not cleared; only bytes of the current frame are read.
module marker_checksum_packet_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_kind,
	output logic [7:0] frame_seq,
	output logic [7:0] payload_byte,
	output logic [2:0] payload_index,
	output logic       run_last,
	output logic [7:0] peer_version,
	output logic [7:0] peer_payload_size,
	output logic [15:0] peer_token,
	output logic [7:0] peer_session_flag
);
	import mcpd_pkg::*;

	state_t            state_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] last_idx_q;
	logic              is_hello_q;
	logic [7:0]        sum_q;
	logic [7:0]        seq_q;
	logic [ADDR_W-1:0] rd_addr_q;

	logic              rx_take;
	logic              ram_we;
	logic [7:0]        ram_rdata;
	logic              frame_end;
	logic              sum_ok;
	logic [ADDR_W-1:0] pay_off;

	assign rx_ready  = (state_q == ST_RECV);
	assign out_valid = (state_q == ST_OUT);
	assign rx_take   = rx_valid && rx_ready;
	assign ram_we    = rx_take && (fill_q >= FILL_W'(2));
	assign frame_end = (fill_q >= FILL_W'(2)) && (fill_q == last_idx_q);
	assign sum_ok    = ((sum_q ^ SUM_MASK) == rx_byte);
	assign pay_off   = rd_addr_q - ADDR_PAYLOAD;

	mcpd_ram #(
		.WIDTH(8),
		.DEPTH(STORE_LEN)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q[ADDR_W-1:0]),
		.wdata(rx_byte),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RECV;
			fill_q     <= '0;
			last_idx_q <= '0;
			is_hello_q <= 1'b0;
			sum_q      <= '0;
			seq_q      <= '0;
			rd_addr_q  <= '0;
		end else begin
			unique case (state_q)
				ST_RECV: begin
					if (rx_take) begin
						priority if (fill_q == '0) begin
							if (rx_byte == MARK_BYTE) begin
								fill_q <= FILL_W'(1);
							end
						end else if (fill_q == FILL_W'(1)) begin
							if (rx_byte == TYPE_HELLO || rx_byte == TYPE_DATA) begin
								is_hello_q <= (rx_byte == TYPE_HELLO);
								last_idx_q <= (rx_byte == TYPE_HELLO) ?
									FILL_W'(HELLO_LEN - 1) : FILL_W'(DATA_LEN - 1);
								sum_q      <= rx_byte;
								fill_q     <= FILL_W'(2);
							end else begin
								fill_q <= '0;
							end
						end else if (frame_end) begin
							fill_q <= '0;
							if (!sum_ok) begin
								state_q <= ST_OUT;
							end else begin
								rd_addr_q <= is_hello_q ? ADDR_VERSION : ADDR_PAYLOAD;
								state_q   <= ST_FETCH;
							end
						end else begin
							if (fill_q == FILL_W'(2)) begin
								seq_q <= rx_byte;
							end
							sum_q  <= sum_q + rx_byte;
							fill_q <= fill_q + FILL_W'(1);
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (is_hello_q && rd_addr_q != ADDR_SESSION) begin
						rd_addr_q <= rd_addr_q + ADDR_W'(1);
						state_q   <= ST_FETCH;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						if (!run_last) begin
							rd_addr_q <= rd_addr_q + ADDR_W'(1);
							state_q   <= ST_FETCH;
						end else begin
							state_q <= ST_RECV;
						end
					end
				end
				default: begin
					state_q <= ST_RECV;
				end
			endcase
		end
	end

	// Result register: set up at frame end (kind, sequence, run_last, other fields cleared), filled by readback.
	always_ff @(posedge clk) begin
		if (state_q == ST_RECV && rx_take && frame_end) begin
			event_kind        <= !sum_ok ? EV_BAD : (is_hello_q ? EV_HELLO : EV_DATA);
			frame_seq         <= seq_q;
			payload_byte      <= '0;
			payload_index     <= '0;
			run_last          <= !sum_ok || is_hello_q;
			peer_version      <= '0;
			peer_payload_size <= '0;
			peer_token        <= '0;
			peer_session_flag <= '0;
		end else if (state_q == ST_LOAD) begin
			if (is_hello_q) begin
				unique case (rd_addr_q)
					ADDR_VERSION:  peer_version      <= ram_rdata;
					ADDR_SIZE:     peer_payload_size <= ram_rdata;
					ADDR_TOKEN_HI: peer_token[15:8]  <= ram_rdata;
					ADDR_TOKEN_LO: peer_token[7:0]   <= ram_rdata;
					ADDR_SESSION:  peer_session_flag <= ram_rdata;
					default: begin
					end
				endcase
			end else begin
				payload_byte  <= ram_rdata;
				payload_index <= pay_off[2:0];
				run_last      <= (rd_addr_q == ADDR_PAY_LAST);
			end
		end
	end

endmodule
